FILE: rtl/core/cpyr_pkg.sv
// ----------------------------------------------------------------------------
// Cartesian to pitch/yaw/range package
// Shared constants and types for the vectoring CORDIC datapath.
// ----------------------------------------------------------------------------
package cpyr_pkg;

    localparam int CORDIC_W    = 64;
    localparam int ANGLE_ACC_W = 32;
    localparam int ATAN_STEPS  = 24;

    typedef logic signed [CORDIC_W-1:0] cordic_word_t;
    typedef logic [ANGLE_ACC_W-1:0]     turn_t;

    localparam turn_t QUARTER_TURN = 32'h4000_0000;
    localparam turn_t HALF_TURN    = 32'h8000_0000;
    localparam turn_t PITCH_WRAP   = 32'hC000_0000;

    localparam turn_t ATAN_TABLE [ATAN_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670675,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

FILE: rtl/core/cpyr_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined rounded square root
// Digit-by-digit root, one result bit per stage, then a rounding stage.
// ----------------------------------------------------------------------------
module cpyr_sqrt #(
    parameter int ROOT_WIDTH = 24
) (
    input  logic                    clk,
    input  logic [2*ROOT_WIDTH-1:0] radicand,
    output logic [ROOT_WIDTH:0]     root
);
    import cpyr_pkg::*;

    localparam int REM_W = ROOT_WIDTH + 2;
    localparam int TRY_W = REM_W + 2;

    logic [REM_W-1:0]        rem_reg   [ROOT_WIDTH];
    logic [REM_W-1:0]        rem_next  [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0]   q_reg     [ROOT_WIDTH];
    logic [ROOT_WIDTH-1:0]   q_next    [ROOT_WIDTH];
    logic [2*ROOT_WIDTH-1:0] rad_reg   [ROOT_WIDTH];
    logic [2*ROOT_WIDTH-1:0] rad_next  [ROOT_WIDTH];
    logic [ROOT_WIDTH:0]     root_reg;
    logic [ROOT_WIDTH:0]     root_next;

    always_comb
    begin
        logic [REM_W-1:0]        rem_cur;
        logic [ROOT_WIDTH-1:0]   q_cur;
        logic [2*ROOT_WIDTH-1:0] rad_cur;
        logic [TRY_W-1:0]        trial;
        logic [TRY_W-1:0]        subtrahend;
        logic [TRY_W-1:0]        diff;
        for (int k = 0; k < ROOT_WIDTH; k++)
        begin
            if (k == 0)
            begin
                rem_cur = '0;
                q_cur   = '0;
                rad_cur = radicand;
            end
            else
            begin
                rem_cur = rem_reg[k-1];
                q_cur   = q_reg[k-1];
                rad_cur = rad_reg[k-1];
            end
            trial      = {rem_cur, rad_cur[2*ROOT_WIDTH-1 -: 2]};
            subtrahend = {2'b00, q_cur, 2'b01};
            diff       = trial - subtrahend;
            if (trial >= subtrahend)
            begin
                rem_next[k] = diff[REM_W-1:0];
                q_next[k]   = {q_cur[ROOT_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[REM_W-1:0];
                q_next[k]   = {q_cur[ROOT_WIDTH-2:0], 1'b0};
            end
            rad_next[k] = rad_cur << 2;
        end
    end

    // The root is rounded to nearest when the remainder exceeds it.
    assign root_next = {1'b0, q_reg[ROOT_WIDTH-1]}
                     + (ROOT_WIDTH+1)'(rem_reg[ROOT_WIDTH-1] > {2'b00, q_reg[ROOT_WIDTH-1]});

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_WIDTH; k++)
        begin
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
            rad_reg[k] <= rad_next[k];
        end
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

FILE: rtl/core/cpyr_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// One micro-rotation per register stage; returns the start angle plus the
// arctangent of y over x for a non-negative x operand.
// ----------------------------------------------------------------------------
module cpyr_cordic #(
    parameter int STEPS = 16
) (
    input  logic                   clk,
    input  cpyr_pkg::cordic_word_t x_in,
    input  cpyr_pkg::cordic_word_t y_in,
    input  cpyr_pkg::turn_t        angle_in,
    output cpyr_pkg::turn_t        angle_out
);
    import cpyr_pkg::*;

    cordic_word_t x_reg     [STEPS];
    cordic_word_t x_next    [STEPS];
    cordic_word_t y_reg     [STEPS];
    cordic_word_t y_next    [STEPS];
    turn_t        angle_reg [STEPS];
    turn_t        angle_next[STEPS];

    always_comb
    begin
        cordic_word_t cx;
        cordic_word_t cy;
        turn_t        ca;
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                cx = x_in;
                cy = y_in;
                ca = angle_in;
            end
            else
            begin
                cx = x_reg[i-1];
                cy = y_reg[i-1];
                ca = angle_reg[i-1];
            end
            if (!cy[CORDIC_W-1])
            begin
                x_next[i]     = cx + (cy >>> i);
                y_next[i]     = cy - (cx >>> i);
                angle_next[i] = ca + ATAN_TABLE[i];
            end
            else
            begin
                x_next[i]     = cx - (cy >>> i);
                y_next[i]     = cy + (cx >>> i);
                angle_next[i] = ca - ATAN_TABLE[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            x_reg[i]     <= x_next[i];
            y_reg[i]     <= y_next[i];
            angle_reg[i] <= angle_next[i];
        end
    end

    assign angle_out = angle_reg[STEPS-1];

endmodule

FILE: rtl/core/cartesian_to_pitch_yaw_range.sv
// ----------------------------------------------------------------------------
// Cartesian to pitch/yaw/range converter
// Converts one signed fixed-point point into pitch, yaw and range.
//
// A transaction is offered by holding coord_x, coord_y and coord_z with start
// high; it is taken at a rising edge where busy is low. busy never rises, so
// one point may be taken on every clock cycle.
// Each result is shown for exactly one cycle with done high, together with
// point_valid, pitch_angle, yaw_angle and range_total. The receiver cannot
// stall the block, and results come out in the order the points went in.
// A point passes the input register, the squares, the sums of squares, the
// square root, the pitch CORDIC and the output register. Throughput is one
// point per cycle: the squaring multipliers, each square root bit and each
// CORDIC micro-rotation occupy a register stage of their own.
// The yaw CORDIC runs from the registered input; the pitch CORDIC waits for
// the horizontal distance from the first square root.
// Reset clears all valid bits in flight, so nothing is reported after reset
// until new points are taken.
// ----------------------------------------------------------------------------
module cartesian_to_pitch_yaw_range #(
    parameter int COORD_WIDTH       = 24,
    parameter int ANGLE_WIDTH       = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          done,
    output logic                          point_valid,
    output logic [ANGLE_WIDTH-1:0]        pitch_angle,
    output logic [ANGLE_WIDTH-1:0]        yaw_angle,
    output logic [COORD_WIDTH-1:0]        range_total
);
    import cpyr_pkg::*;

    localparam int STEPS     = (CORDIC_ITERATIONS < ATAN_STEPS) ? CORDIC_ITERATIONS
                                                                 : ATAN_STEPS;
    localparam int GUARD     = CORDIC_W - 3 - COORD_WIDTH;
    localparam int EXT_W     = CORDIC_W - COORD_WIDTH;
    localparam int SQ_W      = 2 * COORD_WIDTH;
    localparam int ALIGN     = COORD_WIDTH + STEPS + 3;
    localparam int YAW_DLY   = COORD_WIDTH + 3;
    localparam int Z_DLY     = COORD_WIDTH + 3;
    localparam turn_t ROUND_BIAS = turn_t'(1) << (ANGLE_ACC_W - 1 - ANGLE_WIDTH);

    logic                          accept;
    logic                          v1_reg;
    logic signed [COORD_WIDTH-1:0] x1_reg;
    logic signed [COORD_WIDTH-1:0] y1_reg;
    logic signed [COORD_WIDTH-1:0] z1_reg;

    logic signed [SQ_W-1:0]        sqx_next;
    logic signed [SQ_W-1:0]        sqy_next;
    logic signed [SQ_W-1:0]        sqz_next;
    logic [SQ_W-1:0]               sqx_reg;
    logic [SQ_W-1:0]               sqy_reg;
    logic [SQ_W-1:0]               sqz_reg;
    logic [SQ_W-1:0]               hsq_reg;
    logic [SQ_W-1:0]               tot_reg;

    logic                          valid_dly_reg  [ALIGN];
    logic                          origin_dly_reg [ALIGN];
    turn_t                         yaw_dly_reg    [YAW_DLY];
    logic signed [COORD_WIDTH-1:0] z_dly_reg      [Z_DLY];
    logic [COORD_WIDTH-1:0]        range_dly_reg  [STEPS];

    cordic_word_t                  yaw_xw;
    cordic_word_t                  yaw_yw;
    cordic_word_t                  yaw_x_in;
    cordic_word_t                  yaw_y_in;
    turn_t                         yaw_a_in;
    turn_t                         yaw_acc;

    logic [COORD_WIDTH:0]          d_root;
    logic [COORD_WIDTH:0]          r_root;
    logic [COORD_WIDTH-1:0]        range_sat;
    cordic_word_t                  pitch_x_in;
    cordic_word_t                  pitch_y_in;
    turn_t                         pitch_acc;

    turn_t                         pitch_sum;
    turn_t                         pitch_clamped;
    turn_t                         pitch_rnd;
    turn_t                         yaw_sum;
    turn_t                         yaw_rnd;
    logic                          last_valid;
    logic                          last_origin;

    logic                          done_reg;
    logic                          point_valid_reg;
    logic [ANGLE_WIDTH-1:0]        pitch_angle_reg;
    logic [ANGLE_WIDTH-1:0]        yaw_angle_reg;
    logic [COORD_WIDTH-1:0]        range_total_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register, squares and sums of squares.
    always_ff @(posedge clk)
    begin
        x1_reg  <= coord_x;
        y1_reg  <= coord_y;
        z1_reg  <= coord_z;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        sqz_reg <= sqz_next;
        hsq_reg <= sqx_reg + sqy_reg;
        tot_reg <= sqx_reg + sqy_reg + sqz_reg;
    end

    assign sqx_next = x1_reg * x1_reg;
    assign sqy_next = y1_reg * y1_reg;
    assign sqz_next = z1_reg * z1_reg;

    // Yaw pass: a vector in the left half-plane is turned by a half turn first.
    assign yaw_xw = {{EXT_W{x1_reg[COORD_WIDTH-1]}}, x1_reg};
    assign yaw_yw = {{EXT_W{y1_reg[COORD_WIDTH-1]}}, y1_reg};

    always_comb
    begin
        if (x1_reg[COORD_WIDTH-1])
        begin
            yaw_x_in = (-yaw_xw) <<< GUARD;
            yaw_y_in = (-yaw_yw) <<< GUARD;
            yaw_a_in = HALF_TURN;
        end
        else
        begin
            yaw_x_in = yaw_xw <<< GUARD;
            yaw_y_in = yaw_yw <<< GUARD;
            yaw_a_in = '0;
        end
    end

    cpyr_cordic #(
        .STEPS     (STEPS)
    ) u_yaw_cordic (
        .clk       (clk),
        .x_in      (yaw_x_in),
        .y_in      (yaw_y_in),
        .angle_in  (yaw_a_in),
        .angle_out (yaw_acc)
    );

    cpyr_sqrt #(
        .ROOT_WIDTH (COORD_WIDTH)
    ) u_horiz_sqrt (
        .clk        (clk),
        .radicand   (hsq_reg),
        .root       (d_root)
    );

    cpyr_sqrt #(
        .ROOT_WIDTH (COORD_WIDTH)
    ) u_range_sqrt (
        .clk        (clk),
        .radicand   (tot_reg),
        .root       (r_root)
    );

    // The horizontal distance always fits the coordinate width.
    assign pitch_x_in = {{EXT_W{1'b0}}, d_root[COORD_WIDTH-1:0]} <<< GUARD;
    assign pitch_y_in = {{EXT_W{z_dly_reg[Z_DLY-1][COORD_WIDTH-1]}}, z_dly_reg[Z_DLY-1]}
                        <<< GUARD;
    assign range_sat  = r_root[COORD_WIDTH] ? '1 : r_root[COORD_WIDTH-1:0];

    cpyr_cordic #(
        .STEPS     (STEPS)
    ) u_pitch_cordic (
        .clk       (clk),
        .x_in      (pitch_x_in),
        .y_in      (pitch_y_in),
        .angle_in  ('0),
        .angle_out (pitch_acc)
    );

    // Alignment lines for control and payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            for (int i = 0; i < ALIGN; i++)
            begin
                valid_dly_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v1_reg           <= accept;
            valid_dly_reg[0] <= v1_reg;
            for (int i = 1; i < ALIGN; i++)
            begin
                valid_dly_reg[i] <= valid_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        origin_dly_reg[0] <= (x1_reg == '0) && (y1_reg == '0);
        for (int i = 1; i < ALIGN; i++)
        begin
            origin_dly_reg[i] <= origin_dly_reg[i-1];
        end
        yaw_dly_reg[0] <= yaw_acc;
        for (int i = 1; i < YAW_DLY; i++)
        begin
            yaw_dly_reg[i] <= yaw_dly_reg[i-1];
        end
        z_dly_reg[0] <= z1_reg;
        for (int i = 1; i < Z_DLY; i++)
        begin
            z_dly_reg[i] <= z_dly_reg[i-1];
        end
        range_dly_reg[0] <= range_sat;
        for (int i = 1; i < STEPS; i++)
        begin
            range_dly_reg[i] <= range_dly_reg[i-1];
        end
    end

    // Final angle offsets, pitch clamp and rounding.
    assign last_valid  = valid_dly_reg[ALIGN-1];
    assign last_origin = origin_dly_reg[ALIGN-1];
    assign pitch_sum   = QUARTER_TURN + pitch_acc;
    assign yaw_sum     = QUARTER_TURN - yaw_dly_reg[YAW_DLY-1];

    always_comb
    begin
        if (pitch_sum >= PITCH_WRAP)
        begin
            pitch_clamped = '0;
        end
        else if (pitch_sum > HALF_TURN)
        begin
            pitch_clamped = HALF_TURN;
        end
        else
        begin
            pitch_clamped = pitch_sum;
        end
    end

    assign pitch_rnd = pitch_clamped + ROUND_BIAS;
    assign yaw_rnd   = yaw_sum + ROUND_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_origin)
        begin
            point_valid_reg <= 1'b0;
            pitch_angle_reg <= '0;
            yaw_angle_reg   <= '0;
            range_total_reg <= '0;
        end
        else
        begin
            point_valid_reg <= 1'b1;
            pitch_angle_reg <= pitch_rnd[ANGLE_ACC_W-1 -: ANGLE_WIDTH];
            yaw_angle_reg   <= yaw_rnd[ANGLE_ACC_W-1 -: ANGLE_WIDTH];
            range_total_reg <= range_dly_reg[STEPS-1];
        end
    end

    assign done        = done_reg;
    assign point_valid = point_valid_reg;
    assign pitch_angle = pitch_angle_reg;
    assign yaw_angle   = yaw_angle_reg;
    assign range_total = range_total_reg;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Cartesian to pitch/yaw/range converter testbench
// Sends directed points, then random points in bursts with random gaps. A scoreboard
// predicts pitch, yaw and range for each point that is taken, using its own
// vectoring CORDIC and rounded integer square roots. Every result is compared
// field by field, in order, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cpyr_pkg::*;

    localparam int COORD_W       = 24;
    localparam int ANGLE_W       = 16;
    localparam int ITERATIONS    = 16;
    localparam int GUARD         = 61 - COORD_W;
    localparam int RANDOM_POINTS = 1700;
    localparam int SETTLE_CYCLES = 80;
    localparam int TIMEOUT_NS    = 1000000;
    localparam int REPORT_LIMIT  = 10;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic               valid;
        logic [ANGLE_W-1:0] pitch;
        logic [ANGLE_W-1:0] yaw;
        logic [COORD_W-1:0] range;
    } polar_t;

    class PolarScoreboard;
        polar_t predicted[$];
        int     mismatches;
        int     checked;
        int     taken;
        int     void_points;

        function new();
            mismatches  = 0;
            checked     = 0;
            taken       = 0;
            void_points = 0;
        endfunction

        function automatic logic [63:0] root_nearest(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = '0;
            b = 64'h4000_0000_0000_0000;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (v > r)
                r = r + 1;
            return r;
        endfunction

        function automatic turn_t vector_angle(cordic_word_t vx, cordic_word_t vy, turn_t acc);
            cordic_word_t sx;
            cordic_word_t sy;
            for (int i = 0; i < ITERATIONS && i < ATAN_STEPS; i++)
            begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (!vy[CORDIC_W-1])
                begin
                    vx  = vx + sy;
                    vy  = vy - sx;
                    acc = acc + ATAN_TABLE[i];
                end
                else
                begin
                    vx  = vx - sy;
                    vy  = vy + sx;
                    acc = acc - ATAN_TABLE[i];
                end
            end
            return acc;
        endfunction

        function automatic logic [ANGLE_W-1:0] round_turn(turn_t a);
            logic [ANGLE_ACC_W:0] t;
            t = {1'b0, a} + ((ANGLE_ACC_W+1)'(1) << (ANGLE_ACC_W - 1 - ANGLE_W));
            return t[ANGLE_ACC_W-ANGLE_W +: ANGLE_W];
        endfunction

        function automatic polar_t convert_point(coord_t x, coord_t y, coord_t z);
            cordic_word_t sx;
            cordic_word_t sy;
            cordic_word_t sz;
            logic [63:0]  ax;
            logic [63:0]  ay;
            logic [63:0]  az;
            logic [63:0]  hsq;
            logic [63:0]  horiz;
            logic [63:0]  rng;
            turn_t        a1;
            turn_t        a2;
            turn_t        pitch;
            polar_t       res;
            sx  = x;
            sy  = y;
            sz  = z;
            ax  = (sx < 0) ? -sx : sx;
            ay  = (sy < 0) ? -sy : sy;
            az  = (sz < 0) ? -sz : sz;
            hsq = ax * ax + ay * ay;
            res = '0;
            if (hsq == 0)
                return res;
            horiz = root_nearest(hsq);
            rng   = root_nearest(hsq + az * az);
            if (rng > {COORD_W{1'b1}})
                rng = {COORD_W{1'b1}};
            if (sx < 0)
                a1 = vector_angle((-sx) <<< GUARD, (-sy) <<< GUARD, HALF_TURN);
            else
                a1 = vector_angle(sx <<< GUARD, sy <<< GUARD, '0);
            a2    = vector_angle($signed(horiz) <<< GUARD, sz <<< GUARD, '0);
            pitch = QUARTER_TURN + a2;
            if (pitch >= PITCH_WRAP)
                pitch = '0;
            else if (pitch > HALF_TURN)
                pitch = HALF_TURN;
            res.valid = 1'b1;
            res.pitch = round_turn(pitch);
            res.yaw   = round_turn(QUARTER_TURN - a1);
            res.range = rng[COORD_W-1:0];
            return res;
        endfunction

        function void note_point(coord_t x, coord_t y, coord_t z);
            polar_t p;
            p = convert_point(x, y, z);
            if (!p.valid)
                void_points++;
            taken++;
            predicted = {predicted, p};
        endfunction

        function void check_result(polar_t got);
            polar_t want;
            if (predicted.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result: valid=%0b pitch=%0d yaw=%0d range=%0d",
                             got.valid, got.pitch, got.yaw, got.range);
                return;
            end
            want = predicted.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("Result %0d: expected valid=%0b pitch=%0d yaw=%0d range=%0d",
                             checked, want.valid, want.pitch, want.yaw, want.range);
                    $display("Result %0d: got      valid=%0b pitch=%0d yaw=%0d range=%0d",
                             checked, got.valid, got.pitch, got.yaw, got.range);
                end
            end
        endfunction

        function int pending();
            return predicted.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    coord_t             coord_x = '0;
    coord_t             coord_y = '0;
    coord_t             coord_z = '0;
    logic               busy;
    logic               done;
    logic               point_valid;
    logic [ANGLE_W-1:0] pitch_angle;
    logic [ANGLE_W-1:0] yaw_angle;
    logic [COORD_W-1:0] range_total;

    PolarScoreboard scoreboard = new();

    cartesian_to_pitch_yaw_range #(
        .COORD_WIDTH      (COORD_W),
        .ANGLE_WIDTH      (ANGLE_W),
        .CORDIC_ITERATIONS(ITERATIONS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .done       (done),
        .point_valid(point_valid),
        .pitch_angle(pitch_angle),
        .yaw_angle  (yaw_angle),
        .range_total(range_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            scoreboard.check_result({point_valid, pitch_angle, yaw_angle, range_total});
    end

    task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
        start   <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        scoreboard.note_point(x, y, z);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (scoreboard.pending() != 0);
    endtask

    function automatic coord_t random_coord();
        coord_t v;
        v = coord_t'($urandom());
        case ($urandom_range(0, 9))
            0, 1:    v = coord_t'(int'($urandom_range(0, 64)) - 32);
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       v = CMAX;
                    1:       v = CMIN;
                    2:       v = '0;
                    3:       v = coord_t'(1);
                    default: v = coord_t'(-1);
                endcase
            end
            3, 4:    v = v >>> $urandom_range(1, COORD_W - 1);
            default: ;
        endcase
        return v;
    endfunction

    initial
    begin
        int     sent;
        int     burst;
        bit     drained;
        coord_t x;
        coord_t y;
        coord_t z;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_point('0, '0, '0);
        send_point('0, '0, CMAX);
        send_point('0, '0, CMIN);
        send_point(CMAX, '0, '0);
        send_point(CMIN, '0, '0);
        send_point('0, CMAX, '0);
        send_point('0, CMIN, '0);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(CMIN, CMAX, CMIN);
        send_point(CMAX, CMIN, CMAX);
        send_point(coord_t'(1), '0, '0);
        send_point(coord_t'(-1), '0, '0);
        send_point('0, coord_t'(1), '0);
        send_point('0, coord_t'(-1), coord_t'(-1));
        send_point(coord_t'(1), coord_t'(1), coord_t'(1));
        send_point(coord_t'(-1), coord_t'(-1), coord_t'(-1));
        send_point(coord_t'(1), '0, CMAX);
        send_point(coord_t'(1), '0, CMIN);
        send_point(coord_t'(-1), '0, CMAX);
        send_point(coord_t'(-1), CMAX, '0);
        send_point(coord_t'(1), CMAX, '0);
        send_point(coord_t'(-1), CMIN, CMIN);
        wait_for_results();

        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_POINTS)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < RANDOM_POINTS; i++)
            begin
                x = random_coord();
                y = random_coord();
                z = random_coord();
                if ($urandom_range(0, 19) == 0)
                begin
                    x = '0;
                    y = '0;
                end
                send_point(x, y, z);
                sent++;
            end
            if (!drained && sent >= RANDOM_POINTS / 2)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                pause_sender($urandom_range(1, 12));
            end
        end
        pause_sender(1);

        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Converted %0d points, %0d of them on the vertical axis; %0d results checked.",
                 scoreboard.taken, scoreboard.void_points, scoreboard.checked);
        $display("Mismatches: %0d, predictions left unanswered: %0d.",
                 scoreboard.mismatches, scoreboard.pending());
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
            $display("** cartesian_to_pitch_yaw_range: PASSED **");
        else
            $display("** cartesian_to_pitch_yaw_range: FAILED **");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still outstanding.", scoreboard.pending());
        $display("** cartesian_to_pitch_yaw_range: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cpyr_pkg.sv
rtl/core/cpyr_sqrt.sv
rtl/core/cpyr_cordic.sv
rtl/core/cartesian_to_pitch_yaw_range.sv
tb/testbench.sv
